// ===== hdl/scalc_pkg.sv =====
// ----------------------------------------------------------------------------
// scalc_pkg
// shared types, command codes, status codes and radix helpers for the
// stack calculator alu
// ----------------------------------------------------------------------------
package scalc_pkg;

  localparam int unsigned STACK_DEPTH = 5;
  localparam int unsigned WORD_W      = 32;

  typedef logic [WORD_W-1:0] word_t;

  localparam logic [1:0] RADIX_RESET = 2'd2;

  localparam logic [1:0] RADIX_BIN = 2'd0;
  localparam logic [1:0] RADIX_OCT = 2'd1;
  localparam logic [1:0] RADIX_DEC = 2'd2;
  localparam logic [1:0] RADIX_HEX = 2'd3;

  localparam logic [2:0] FUNC_ALU     = 3'd0;
  localparam logic [2:0] FUNC_SWAP    = 3'd1;
  localparam logic [2:0] FUNC_ROLL_UP = 3'd2;
  localparam logic [2:0] FUNC_ROLL_DN = 3'd3;
  localparam logic [2:0] FUNC_DIGIT   = 3'd4;

  localparam logic [3:0] OP_ADD  = 4'd0;
  localparam logic [3:0] OP_SUB  = 4'd1;
  localparam logic [3:0] OP_MUL  = 4'd2;
  localparam logic [3:0] OP_DIV  = 4'd3;
  localparam logic [3:0] OP_LAND = 4'd4;
  localparam logic [3:0] OP_LOR  = 4'd5;
  localparam logic [3:0] OP_LNOT = 4'd6;
  localparam logic [3:0] OP_AND  = 4'd7;
  localparam logic [3:0] OP_OR   = 4'd8;
  localparam logic [3:0] OP_NOT  = 4'd9;
  localparam logic [3:0] OP_XOR  = 4'd10;
  localparam logic [3:0] OP_SHL  = 4'd11;
  localparam logic [3:0] OP_SHR  = 4'd12;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_DIV0  = 2'd1;
  localparam logic [1:0] STAT_DIGIT = 2'd2;

  localparam word_t POW10 [10] = '{
    32'd1, 32'd10, 32'd100, 32'd1000, 32'd10000, 32'd100000,
    32'd1000000, 32'd10000000, 32'd100000000, 32'd1000000000
  };

  function automatic logic [4:0] radix_of(input logic [1:0] mode);
    logic [4:0] r;
    case (mode)
      RADIX_BIN: r = 5'd2;
      RADIX_OCT: r = 5'd8;
      RADIX_DEC: r = 5'd10;
      default:   r = 5'd16;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] max_pos_of(input logic [1:0] mode);
    logic [4:0] p;
    case (mode)
      RADIX_BIN: p = 5'd31;
      RADIX_OCT: p = 5'd10;
      RADIX_DEC: p = 5'd9;
      default:   p = 5'd7;
    endcase
    return p;
  endfunction

  // pos is already saturated to the largest position of the radix
  function automatic word_t weight_of(input logic [1:0] mode, input logic [4:0] pos);
    word_t w;
    case (mode)
      RADIX_BIN: w = word_t'(1) << pos;
      RADIX_OCT: w = word_t'(1) << ({1'b0, pos} * 6'd3);
      RADIX_DEC: w = POW10[pos[3:0]];
      default:   w = word_t'(1) << ({1'b0, pos} * 6'd4);
    endcase
    return w;
  endfunction

endpackage

// ===== hdl/scalc_intf.sv =====
// ----------------------------------------------------------------------------
// scalc_intf
// valid/ready channels for command requests and result requests
// ----------------------------------------------------------------------------
interface scalc_cmd_if;
  logic       valid;
  logic       ready;
  logic [2:0] func;
  logic [3:0] alu_op;
  logic [3:0] digit_value;
  logic [4:0] digit_pos;

  modport source (output valid, output func, output alu_op, output digit_value,
                  output digit_pos, input ready);
  modport sink   (input valid, input func, input alu_op, input digit_value,
                  input digit_pos, output ready);
endinterface

interface scalc_res_if;
  logic        valid;
  logic        ready;
  logic [31:0] top_value;
  logic [31:0] second_value;
  logic [1:0]  status;

  modport source (output valid, output top_value, output second_value, output status,
                  input ready);
  modport sink   (input valid, input top_value, input second_value, input status,
                  output ready);
endinterface

// ===== hdl/scalc_mul.sv =====
// ----------------------------------------------------------------------------
// scalc_mul
// bit-serial shift-add multiplier, one multiplier bit per cycle, product
// truncated to the word width
// ----------------------------------------------------------------------------
module scalc_mul #(
  parameter int unsigned WIDTH = scalc_pkg::WORD_W
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [WIDTH-1:0] a_i,
  input  logic [WIDTH-1:0] b_i,
  output logic             done_o,
  output logic [WIDTH-1:0] prod_o
);

  localparam int unsigned CNT_W = $clog2(WIDTH);

  logic [WIDTH-1:0] a_q, b_q, acc_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q, done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      a_q    <= '0;
      b_q    <= '0;
      acc_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
      a_q    <= a_i;
      b_q    <= b_i;
      acc_q  <= '0;
    end else if (busy_q) begin
      if (a_q[0]) begin
        acc_q <= acc_q + b_q;
      end
      a_q   <= a_q >> 1;
      b_q   <= b_q << 1;
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CNT_W'(WIDTH - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

// ===== hdl/scalc_div.sv =====
// ----------------------------------------------------------------------------
// scalc_div
// bit-serial restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module scalc_div #(
  parameter int unsigned WIDTH = scalc_pkg::WORD_W
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [WIDTH-1:0] dividend_i,
  input  logic [WIDTH-1:0] divisor_i,
  output logic             done_o,
  output logic [WIDTH-1:0] quot_o,
  output logic [WIDTH-1:0] rem_o
);

  localparam int unsigned CNT_W = $clog2(WIDTH);

  logic [WIDTH-1:0] q_q, r_q, d_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q, done_q;
  logic [WIDTH:0]   shifted, diff;

  assign shifted = {r_q, q_q[WIDTH-1]};
  assign diff    = shifted - {1'b0, d_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      q_q    <= '0;
      r_q    <= '0;
      d_q    <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
      q_q    <= dividend_i;
      r_q    <= '0;
      d_q    <= divisor_i;
    end else if (busy_q) begin
      if (!diff[WIDTH]) begin
        r_q <= diff[WIDTH-1:0];
        q_q <= {q_q[WIDTH-2:0], 1'b1};
      end else begin
        r_q <= shifted[WIDTH-1:0];
        q_q <= {q_q[WIDTH-2:0], 1'b0};
      end
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CNT_W'(WIDTH - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  assign done_o = done_q;
  assign quot_o = q_q;
  assign rem_o  = r_q;

endmodule

// ===== hdl/stack_calculator_alu_core.sv =====
// ----------------------------------------------------------------------------
// stack_calculator_alu_core
// rpn stack calculator datapath with serial multiply, divide and digit
// replacement
// ----------------------------------------------------------------------------
// One command request is taken at a time and gives one result request with
// the top two stack words and a status. Swap, roll and the combinational alu
// operations go from idle to the write-back state, which loads the result
// register once it is free. Multiply and divide run on bit-serial units
// that take one bit per cycle before they go to write-back.
// Setting a digit runs the serial divider twice (top word by the digit
// weight, then by the radix), then adds the change. A finished result waits in
// an output register, and the next command is taken while it waits; that
// command's result then holds until the waiting one is taken.
module stack_calculator_alu_core #(
  parameter int unsigned STACK_DEPTH = scalc_pkg::STACK_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_wdata_i,
  scalc_cmd_if.sink          cmd_i,
  scalc_res_if.source        res_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_DIV, S_DIG_DIV1, S_DIG_DIV2, S_DIG_ADD, S_WB
  } state_e;

  state_e               state_q;
  scalc_pkg::word_t     stack_q [STACK_DEPTH];
  scalc_pkg::word_t     stack_d [STACK_DEPTH];
  logic [1:0]           radix_q;
  logic [2:0]           func_q;
  logic [3:0]           dval_q;
  logic [4:0]           base_q;
  scalc_pkg::word_t     w_q, delta_q, res_top_q;
  logic [1:0]           status_q;
  logic                 out_valid_q;
  scalc_pkg::word_t     out_top_q, out_second_q;
  logic [1:0]           out_status_q;
  logic                 mul_start_q, div_start_q;
  scalc_pkg::word_t     div_a_q, div_b_q;

  logic                 mul_done, div_done;
  scalc_pkg::word_t     mul_prod, div_quot, div_rem;
  scalc_pkg::word_t     top_w, sec_w, alu_res, weight;
  logic [4:0]           radix, max_pos, pos_sat;

  scalc_mul #(.WIDTH(scalc_pkg::WORD_W)) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start_q),
    .a_i     (stack_q[0]),
    .b_i     (stack_q[1]),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  scalc_div #(.WIDTH(scalc_pkg::WORD_W)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start_q),
    .dividend_i (div_a_q),
    .divisor_i  (div_b_q),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  assign top_w   = stack_q[0];
  assign sec_w   = stack_q[1];
  assign radix   = scalc_pkg::radix_of(radix_q);
  assign max_pos = scalc_pkg::max_pos_of(radix_q);
  assign pos_sat = (cmd_i.digit_pos > max_pos) ? max_pos : cmd_i.digit_pos;
  assign weight  = scalc_pkg::weight_of(radix_q, pos_sat);

  always_comb begin
    case (cmd_i.alu_op)
      scalc_pkg::OP_ADD:  alu_res = top_w + sec_w;
      scalc_pkg::OP_SUB:  alu_res = top_w - sec_w;
      scalc_pkg::OP_LAND: alu_res = scalc_pkg::word_t'((top_w != '0) && (sec_w != '0));
      scalc_pkg::OP_LOR:  alu_res = scalc_pkg::word_t'((top_w != '0) || (sec_w != '0));
      scalc_pkg::OP_LNOT: alu_res = scalc_pkg::word_t'(top_w == '0);
      scalc_pkg::OP_AND:  alu_res = top_w & sec_w;
      scalc_pkg::OP_OR:   alu_res = top_w | sec_w;
      scalc_pkg::OP_NOT:  alu_res = ~top_w;
      scalc_pkg::OP_XOR:  alu_res = top_w ^ sec_w;
      scalc_pkg::OP_SHL:  alu_res = top_w << 1;
      scalc_pkg::OP_SHR:  alu_res = top_w >> 1;
      default:            alu_res = top_w;
    endcase
  end

  always_comb begin
    for (int i = 0; i < STACK_DEPTH; i++) begin
      stack_d[i] = stack_q[i];
    end
    case (func_q)
      scalc_pkg::FUNC_ALU, scalc_pkg::FUNC_DIGIT: begin
        stack_d[0] = res_top_q;
      end
      scalc_pkg::FUNC_SWAP: begin
        stack_d[0] = stack_q[1];
        stack_d[1] = stack_q[0];
      end
      scalc_pkg::FUNC_ROLL_UP: begin
        for (int i = 1; i < STACK_DEPTH; i++) begin
          stack_d[i] = stack_q[i-1];
        end
      end
      scalc_pkg::FUNC_ROLL_DN: begin
        for (int i = 0; i < STACK_DEPTH - 1; i++) begin
          stack_d[i] = stack_q[i+1];
        end
      end
      default: begin
      end
    endcase
  end

  assign cmd_i.ready        = (state_q == S_IDLE);
  assign res_o.valid        = out_valid_q;
  assign res_o.top_value    = out_top_q;
  assign res_o.second_value = out_second_q;
  assign res_o.status       = out_status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      for (int i = 0; i < STACK_DEPTH; i++) begin
        stack_q[i] <= '0;
      end
      radix_q      <= scalc_pkg::RADIX_RESET;
      func_q       <= '0;
      dval_q       <= '0;
      base_q       <= '0;
      w_q          <= '0;
      delta_q      <= '0;
      res_top_q    <= '0;
      status_q     <= scalc_pkg::STAT_OK;
      out_valid_q  <= 1'b0;
      out_top_q    <= '0;
      out_second_q <= '0;
      out_status_q <= scalc_pkg::STAT_OK;
      mul_start_q  <= 1'b0;
      div_start_q  <= 1'b0;
      div_a_q      <= '0;
      div_b_q      <= '0;
    end else begin
      mul_start_q <= 1'b0;
      div_start_q <= 1'b0;
      if (cfg_we_i) begin
        radix_q <= cfg_wdata_i;
      end
      if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (cmd_i.valid) begin
            func_q    <= cmd_i.func;
            status_q  <= scalc_pkg::STAT_OK;
            res_top_q <= top_w;
            state_q   <= S_WB;
            case (cmd_i.func)
              scalc_pkg::FUNC_ALU: begin
                if (cmd_i.alu_op == scalc_pkg::OP_MUL) begin
                  mul_start_q <= 1'b1;
                  state_q     <= S_MUL;
                end else if (cmd_i.alu_op == scalc_pkg::OP_DIV) begin
                  if (sec_w == '0) begin
                    status_q <= scalc_pkg::STAT_DIV0;
                  end else begin
                    div_a_q     <= top_w;
                    div_b_q     <= sec_w;
                    div_start_q <= 1'b1;
                    state_q     <= S_DIV;
                  end
                end else begin
                  res_top_q <= alu_res;
                end
              end
              scalc_pkg::FUNC_DIGIT: begin
                if ({1'b0, cmd_i.digit_value} >= radix) begin
                  status_q <= scalc_pkg::STAT_DIGIT;
                end else begin
                  dval_q      <= cmd_i.digit_value;
                  base_q      <= radix;
                  w_q         <= weight;
                  div_a_q     <= top_w;
                  div_b_q     <= weight;
                  div_start_q <= 1'b1;
                  state_q     <= S_DIG_DIV1;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_MUL: begin
          if (mul_done) begin
            res_top_q <= mul_prod;
            state_q   <= S_WB;
          end
        end
        S_DIV: begin
          if (div_done) begin
            res_top_q <= div_quot;
            state_q   <= S_WB;
          end
        end
        S_DIG_DIV1: begin
          if (div_done) begin
            div_a_q     <= div_quot;
            div_b_q     <= scalc_pkg::word_t'(base_q);
            div_start_q <= 1'b1;
            state_q     <= S_DIG_DIV2;
          end
        end
        S_DIG_DIV2: begin
          if (div_done) begin
            delta_q <= (scalc_pkg::word_t'(dval_q) * w_q)
                     - (scalc_pkg::word_t'(div_rem[3:0]) * w_q);
            state_q <= S_DIG_ADD;
          end
        end
        S_DIG_ADD: begin
          res_top_q <= top_w + delta_q;
          state_q   <= S_WB;
        end
        S_WB: begin
          if (!out_valid_q || res_o.ready) begin
            for (int i = 0; i < STACK_DEPTH; i++) begin
              stack_q[i] <= stack_d[i];
            end
            out_top_q    <= stack_d[0];
            out_second_q <= stack_d[1];
            out_status_q <= status_q;
            out_valid_q  <= 1'b1;
            state_q      <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hdl/scalc_checker.sv =====
// ----------------------------------------------------------------------------
// scalc_checker
// port-level checks for the stack calculator alu, bound to the core module
// ----------------------------------------------------------------------------
module scalc_assert_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        cmd_valid_i,
  input logic        cmd_ready_i,
  input logic        res_valid_i,
  input logic        res_ready_i,
  input logic [31:0] res_top_i,
  input logic [31:0] res_second_i,
  input logic [1:0]  res_status_i
);

  // stalled result request holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_top_i)
      && $stable(res_second_i) && $stable(res_status_i))
    else $error("stalled result changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> (res_status_i == scalc_pkg::STAT_OK)
      || (res_status_i == scalc_pkg::STAT_DIV0)
      || (res_status_i == scalc_pkg::STAT_DIGIT))
    else $error("illegal status code");

  // one command in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid_i && cmd_ready_i |=> !cmd_ready_i)
    else $error("command taken while busy");

  // a new result only follows a busy cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid_i) |-> $past(!cmd_ready_i))
    else $error("result without command work");

endmodule

bind stack_calculator_alu_core scalc_assert_checker u_scalc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .cmd_valid_i  (cmd_i.valid),
  .cmd_ready_i  (cmd_i.ready),
  .res_valid_i  (res_o.valid),
  .res_ready_i  (res_o.ready),
  .res_top_i    (res_o.top_value),
  .res_second_i (res_o.second_value),
  .res_status_i (res_o.status)
);

// ===== bench/scalc_checker.sv =====
// ----------------------------------------------------------------------------
// scalc_checker
// Watches the command and result channels of the stack calculator alu. It
// keeps its own copy of the stack and the radix, predicts the top two words
// and the status for every command request it sees accepted, and compares
// each accepted result request with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module scalc_checker
  import scalc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_wdata_i,
  scalc_cmd_if        cmd_i,
  scalc_res_if        res_i,
  output int unsigned mismatch_count_o,
  output int unsigned pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    word_t      top;
    word_t      second;
    logic [1:0] status;
  } stack_view_t;

  word_t       stack_q [STACK_DEPTH];
  logic [1:0]  radix_q;
  stack_view_t expected_views [$];
  int unsigned errors = 0;

  assign mismatch_count_o = errors;

  task automatic flag_error(input string msg);
    $display("[%0t] scalc_checker: %s", $time, msg);
    errors++;
  endtask

  function automatic stack_view_t predict_command(input logic [2:0] func,
                                                  input logic [3:0] op,
                                                  input logic [3:0] dval,
                                                  input logic [4:0] dpos);
    stack_view_t v;
    word_t       a;
    word_t       b;
    logic [63:0] base;
    logic [63:0] w;
    logic [63:0] full;
    logic [63:0] old;
    logic [4:0]  maxp;
    logic [4:0]  pos;
    int          i;
    a        = stack_q[0];
    b        = stack_q[1];
    v.status = STAT_OK;
    case (func)
      FUNC_ALU: begin
        case (op)
          OP_ADD:  stack_q[0] = a + b;
          OP_SUB:  stack_q[0] = a - b;
          OP_MUL:  stack_q[0] = a * b;
          OP_DIV: begin
            if (b == '0) v.status = STAT_DIV0;
            else         stack_q[0] = a / b;
          end
          OP_LAND: stack_q[0] = word_t'((a != '0) && (b != '0));
          OP_LOR:  stack_q[0] = word_t'((a != '0) || (b != '0));
          OP_LNOT: stack_q[0] = word_t'(a == '0);
          OP_AND:  stack_q[0] = a & b;
          OP_OR:   stack_q[0] = a | b;
          OP_NOT:  stack_q[0] = ~a;
          OP_XOR:  stack_q[0] = a ^ b;
          OP_SHL:  stack_q[0] = a << 1;
          OP_SHR:  stack_q[0] = a >> 1;
          default: ;
        endcase
      end
      FUNC_SWAP: begin
        stack_q[0] = b;
        stack_q[1] = a;
      end
      FUNC_ROLL_UP: begin
        for (i = STACK_DEPTH - 1; i > 0; i--) stack_q[i] = stack_q[i-1];
      end
      FUNC_ROLL_DN: begin
        for (i = 0; i < STACK_DEPTH - 1; i++) stack_q[i] = stack_q[i+1];
      end
      FUNC_DIGIT: begin
        case (radix_q)
          RADIX_BIN: begin base = 64'd2;  maxp = 5'd31; end
          RADIX_OCT: begin base = 64'd8;  maxp = 5'd10; end
          RADIX_DEC: begin base = 64'd10; maxp = 5'd9;  end
          default:   begin base = 64'd16; maxp = 5'd7;  end
        endcase
        if (64'(dval) >= base) begin
          v.status = STAT_DIGIT;
        end else begin
          pos = (dpos > maxp) ? maxp : dpos;
          w   = 64'd1;
          for (i = 0; i < int'(pos); i++) w = w * base;
          full = {32'd0, a};
          old  = (full / w) % base;
          // the topmost partial digit may overflow, keep the low word
          full = full - old * w + 64'(dval) * w;
          stack_q[0] = full[31:0];
        end
      end
      default: ;
    endcase
    v.top    = stack_q[0];
    v.second = stack_q[1];
    return v;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    stack_view_t got;
    stack_view_t want;
    int          i;
    if (!rst_ni) begin
      for (i = 0; i < STACK_DEPTH; i++) stack_q[i] = '0;
      radix_q = RADIX_RESET;
      expected_views.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) radix_q = cfg_wdata_i;
      if (res_i.valid === 1'b1 && res_i.ready === 1'b1) begin
        got.top    = res_i.top_value;
        got.second = res_i.second_value;
        got.status = res_i.status;
        if (expected_views.size() == 0) begin
          flag_error($sformatf("result request with no command pending: top %h second %h status %0d",
                               got.top, got.second, got.status));
        end else begin
          want = expected_views.pop_front();
          if (got.top !== want.top)
            flag_error($sformatf("top_value %h, expected %h", got.top, want.top));
          if (got.second !== want.second)
            flag_error($sformatf("second_value %h, expected %h", got.second, want.second));
          if (got.status !== want.status)
            flag_error($sformatf("status %0d, expected %0d", got.status, want.status));
        end
      end
      if (cmd_i.valid === 1'b1 && cmd_i.ready === 1'b1)
        expected_views.push_back(predict_command(cmd_i.func, cmd_i.alu_op,
                                                 cmd_i.digit_value, cmd_i.digit_pos));
      pending_o <= expected_views.size();
    end
  end

endmodule

// ===== bench/tb_stack_calculator_alu_core.sv =====
// ----------------------------------------------------------------------------
// tb_stack_calculator_alu_core
// Drives command requests into the stack calculator alu core: a directed
// pass over every command, every alu operation, divide by zero, digit
// saturation, overflow and rejection, then random commands under each
// radix. Both channels idle at random, and the result side holds off for
// long stretches so the core backs up. A checker beside the core predicts
// and compares; this module only drives and gives the verdict.
// ----------------------------------------------------------------------------
module tb_stack_calculator_alu_core;
  timeunit 1ns;
  timeprecision 1ps;

  import scalc_pkg::*;

  localparam logic [3:0]  OP_UNUSED_LO   = 4'd13;
  localparam logic [3:0]  OP_UNUSED_HI   = 4'd15;
  localparam logic [2:0]  FUNC_UNUSED_LO = 3'd5;
  localparam logic [2:0]  FUNC_UNUSED_HI = 3'd7;
  localparam int unsigned MAX_GAP        = 16;
  localparam int unsigned RAND_PER_PHASE = 238;
  localparam int unsigned NUM_PHASES     = 6;
  localparam int unsigned DRAIN_CYCLES   = 120;
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned CYCLE_LIMIT    = 1_000_000;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        cfg_we    = 1'b0;
  logic [1:0]  cfg_wdata = RADIX_RESET;
  logic [1:0]  cur_radix = RADIX_RESET;
  int unsigned mismatch_count;
  int unsigned pending;
  int unsigned sent_count  = 0;
  int unsigned cycle_count = 0;

  scalc_cmd_if cmd_if ();
  scalc_res_if res_if ();

  stack_calculator_alu_core i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .cmd_i       (cmd_if),
    .res_o       (res_if)
  );

  scalc_checker i_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_wdata_i      (cfg_wdata),
    .cmd_i            (cmd_if),
    .res_i            (res_if),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_stack_calculator_alu_core: errors");
      $finish;
    end
  end

  // every fourth stretch of 64 requests runs without gaps
  function automatic int unsigned idle_gap(input int unsigned n);
    if ((n / 64) % 4 == 1) return 0;
    return $urandom_range(0, MAX_GAP);
  endfunction

  task automatic send_cmd(input logic [2:0] f, input logic [3:0] op,
                          input logic [3:0] dv, input logic [4:0] dp);
    int unsigned gap;
    gap = idle_gap(sent_count);
    if (gap > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_if.valid       <= 1'b1;
    cmd_if.func        <= f;
    cmd_if.alu_op      <= op;
    cmd_if.digit_value <= dv;
    cmd_if.digit_pos   <= dp;
    do @(posedge clk); while (!(cmd_if.valid === 1'b1 && cmd_if.ready === 1'b1));
    sent_count++;
  endtask

  task automatic send_alu(input logic [3:0] op);
    send_cmd(FUNC_ALU, op, 4'd0, 5'd0);
  endtask

  task automatic send_random();
    logic [2:0]  f;
    logic [3:0]  op;
    logic [3:0]  dv;
    logic [4:0]  dp;
    int unsigned base;
    int unsigned pick;
    case (cur_radix)
      RADIX_BIN: base = 2;
      RADIX_OCT: base = 8;
      RADIX_DEC: base = 10;
      default:   base = 16;
    endcase
    dp = 5'($urandom_range(0, 31));
    if ($urandom_range(0, 9) == 0) begin
      f  = 3'($urandom_range(FUNC_ALU, FUNC_UNUSED_HI));
      op = 4'($urandom_range(OP_ADD, OP_UNUSED_HI));
      dv = 4'($urandom_range(0, 15));
    end else begin
      pick = $urandom_range(0, 9);
      case (pick)
        0, 1, 2, 3: f = FUNC_ALU;
        4:          f = FUNC_SWAP;
        5:          f = FUNC_ROLL_UP;
        6:          f = FUNC_ROLL_DN;
        default:    f = FUNC_DIGIT;
      endcase
      op = 4'($urandom_range(OP_ADD, OP_SHR));
      dv = 4'($urandom_range(0, base - 1));
    end
    send_cmd(f, op, dv, dp);
  endtask

  task automatic wait_idle();
    cmd_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_radix(input logic [1:0] r);
    cfg_we    <= 1'b1;
    cfg_wdata <= r;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_radix  = r;
  endtask

  // result side: random gaps, two long hold-offs while commands keep coming
  initial begin
    int unsigned gap;
    int unsigned taken;
    taken        = 0;
    res_if.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (taken == 300 || taken == 1000) gap = HOLD_CYCLES;
      else                               gap = idle_gap(taken);
      if (gap > 0) begin
        res_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk); while (!(res_if.valid === 1'b1 && res_if.ready === 1'b1));
      taken++;
    end
  end

  initial begin
    logic [1:0]  radix_plan [NUM_PHASES];
    int unsigned phase;
    cmd_if.valid       = 1'b0;
    cmd_if.func        = FUNC_ALU;
    cmd_if.alu_op      = OP_ADD;
    cmd_if.digit_value = 4'd0;
    cmd_if.digit_pos   = 5'd0;
    radix_plan[0] = RADIX_BIN;
    radix_plan[1] = RADIX_HEX;
    radix_plan[2] = RADIX_OCT;
    radix_plan[3] = RADIX_DEC;
    radix_plan[4] = 2'($urandom_range(0, 3));
    radix_plan[5] = 2'($urandom_range(0, 3));
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed pass at the reset radix
    send_alu(OP_DIV);
    send_alu(OP_LNOT);
    send_alu(OP_DIV);
    send_cmd(FUNC_ROLL_UP, 4'd0, 4'd0, 5'd0);
    send_alu(OP_ADD);
    send_alu(OP_NOT);
    send_cmd(FUNC_ROLL_UP, 4'd0, 4'd0, 5'd0);
    send_alu(OP_MUL);
    send_alu(OP_SUB);
    send_cmd(FUNC_SWAP, 4'd0, 4'd0, 5'd0);
    send_alu(OP_DIV);
    send_alu(OP_LAND);
    send_alu(OP_LOR);
    send_alu(OP_AND);
    send_alu(OP_OR);
    send_alu(OP_XOR);
    send_alu(OP_SHL);
    send_alu(OP_SHR);
    send_cmd(FUNC_ROLL_DN, 4'd0, 4'd0, 5'd0);
    send_alu(OP_UNUSED_LO);
    send_cmd(FUNC_ALU, OP_UNUSED_HI, 4'd15, 5'd31);
    send_cmd(FUNC_UNUSED_LO, OP_ADD, 4'd0, 5'd0);
    send_cmd(FUNC_UNUSED_HI, OP_UNUSED_HI, 4'd15, 5'd31);
    send_cmd(FUNC_DIGIT, OP_ADD, 4'd9, 5'd31);
    send_cmd(FUNC_DIGIT, OP_ADD, 4'd15, 5'd0);
    send_cmd(FUNC_DIGIT, OP_ADD, 4'd0, 5'd0);
    send_cmd(FUNC_DIGIT, OP_ADD, 4'd5, 5'd3);

    for (phase = 0; phase < NUM_PHASES; phase++) begin
      wait_idle();
      write_radix(radix_plan[phase]);
      repeat (RAND_PER_PHASE) send_random();
    end
    wait_idle();

    if (mismatch_count == 0 && pending == 0) begin
      $display("tb_stack_calculator_alu_core: clean");
    end else begin
      $display("tb_stack_calculator_alu_core: errors");
    end
    $finish;
  end

endmodule
